### sv/ubds_pkg.sv
// ============================================================================
// ubds_pkg
// Shared types and fixed widths for the UART baud divisor selector.
// ============================================================================
package ubds_pkg;

   // Fixed field widths
   localparam int BAUD_BITS     = 20;
   localparam int CLOCK_BITS    = 32;
   localparam int ERROR_BITS    = 32;

   // Oversampling ratios as shift amounts: 16 for normal, 8 for double speed
   localparam int NORMAL_SHIFT  = 4;
   localparam int DOUBLE_SHIFT  = 3;

   // Divisor is baud times 16 at most
   localparam int DVSR_BITS     = BAUD_BITS + NORMAL_SHIFT;

   // One quotient bit per divider step
   localparam int STEP_BITS     = $clog2(CLOCK_BITS);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(CLOCK_BITS - 1);

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_FIN  = 4'b0100,
      ST_SEL  = 4'b1000
   } state_type;

   // Outcome of one oversampling ratio
   typedef struct packed {
      logic                  usable;
      logic [DVSR_BITS-1:0]  err;
      logic [CLOCK_BITS-1:0] value;
   } cand_type;

endpackage

### sv/ubds_if.sv
// ============================================================================
// ubds_if
// Valid/ready channels for the baud divisor selector: request and response.
// ============================================================================
interface ubds_req_if
   import ubds_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [BAUD_BITS-1:0]  baud_rate;
   logic [CLOCK_BITS-1:0] clock_frequency;

   modport source (output valid, output baud_rate, output clock_frequency, input ready);
   modport sink   (input valid, input baud_rate, input clock_frequency, output ready);
endinterface

interface ubds_rsp_if
   import ubds_pkg::*;
   #(parameter int DIVISOR_BITS = 12)
   ();
   logic                    valid;
   logic                    ready;
   logic [DIVISOR_BITS-1:0] divisor_value;
   logic                    double_speed;
   logic [ERROR_BITS-1:0]   rate_error;
   logic                    out_of_range;
   logic                    invalid_request;

   modport source (output valid, output divisor_value, output double_speed,
                   output rate_error, output out_of_range, output invalid_request,
                   input ready);
   modport sink   (input valid, input divisor_value, input double_speed,
                   input rate_error, input out_of_range, input invalid_request,
                   output ready);
endinterface

### sv/uart_baud_divisor_select.sv
// ============================================================================
// uart_baud_divisor_select
// Picks the UART divisor and oversampling mode (16 or 8) with the smaller
// rounding error for a requested baud rate and clock frequency.
// ============================================================================
//
//  channel   direction  payload
//  --------  ---------  -------------------------------------------------------
//  req_bus   in         baud_rate[19:0], clock_frequency[31:0]
//  rsp_bus   out        divisor_value, double_speed, rate_error[31:0],
//                       out_of_range, invalid_request
//
//  After a request is accepted, a restoring divider produces one quotient
//  bit per cycle, 32 steps for each ratio; each ratio is then rounded, and
//  a selection state picks the response.
//  req_bus.ready is high only while the sequencer is idle.
//  The response sits in an output register; a new request is accepted while
//  it waits, and only the final selection holds until the register is free.
//  Synchronous active-high reset clears the sequencer and the response valid.
//
module uart_baud_divisor_select
   import ubds_pkg::*;
   #(parameter int DIVISOR_BITS = 12)
   (
   input  logic       clock,
   input  logic       reset,
   ubds_req_if.sink   req_bus,
   ubds_rsp_if.source rsp_bus
   );

   localparam int DVSR_EXT = DVSR_BITS + 1;

   // Sequencer
   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  pass_ff, pass_in;

   // Operands and divider datapath
   logic [BAUD_BITS-1:0]  baud_ff, baud_in;
   logic [CLOCK_BITS-1:0] clock_ff, clock_in;
   logic [DVSR_BITS-1:0]  dvsr_ff, dvsr_in;
   logic [DVSR_BITS-1:0]  rem_ff, rem_in;
   logic [CLOCK_BITS-1:0] quo_ff, quo_in;

   // Candidates
   cand_type              norm_ff, norm_in;
   cand_type              dbl_ff, dbl_in;

   // Response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DIVISOR_BITS-1:0] div_ff, div_in;
   logic                    dspd_ff, dspd_in;
   logic [ERROR_BITS-1:0]   err_ff, err_in;
   logic                    oor_ff, oor_in;
   logic                    inv_ff, inv_in;

   // Shared divider step and rounding
   logic [DVSR_EXT-1:0]   rem_shift;
   logic [DVSR_EXT:0]     diff;
   logic                  ge;
   logic                  round_up;
   cand_type              cand;

   // Selection
   logic [DVSR_EXT-1:0]   key_norm;
   logic [DVSR_EXT-1:0]   key_dbl;
   logic                  pick_dbl;
   cand_type              chosen;
   logic                  sat;

   // One restoring division step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[CLOCK_BITS-1]};
      diff      = {1'b0, rem_shift} - {2'b00, dvsr_ff};
      ge        = !diff[DVSR_EXT];
   end

   // Round the finished quotient and form the candidate
   always_comb begin
      round_up    = rem_ff > (dvsr_ff >> 1);
      cand.usable = (dvsr_ff != '0) && (quo_ff != '0);
      cand.err    = round_up ? (dvsr_ff - rem_ff) : rem_ff;
      cand.value  = round_up ? quo_ff : (quo_ff - CLOCK_BITS'(1));
   end

   // Compare the two candidates; unusable ones count as maximal error
   always_comb begin
      key_norm = norm_ff.usable ? {1'b0, norm_ff.err} : '1;
      key_dbl  = dbl_ff.usable ? {1'b0, dbl_ff.err} : '1;
      pick_dbl = key_norm > key_dbl;
      chosen   = pick_dbl ? dbl_ff : norm_ff;
      sat      = |chosen.value[CLOCK_BITS-1:DIVISOR_BITS];
   end

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      pass_in      = pass_ff;
      baud_in      = baud_ff;
      clock_in     = clock_ff;
      dvsr_in      = dvsr_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      norm_in      = norm_ff;
      dbl_in       = dbl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      div_in       = div_ff;
      dspd_in      = dspd_ff;
      err_in       = err_ff;
      oor_in       = oor_ff;
      inv_in       = inv_ff;

      case (state_ff)
         ST_IDLE: begin
            // Load the request and start the normal-speed division
            if (req_bus.valid) begin
               baud_in  = req_bus.baud_rate;
               clock_in = req_bus.clock_frequency;
               dvsr_in  = DVSR_BITS'(req_bus.baud_rate) << NORMAL_SHIFT;
               rem_in   = '0;
               quo_in   = req_bus.clock_frequency;
               step_in  = '0;
               pass_in  = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // Shift in one dividend bit, subtract when it fits
            rem_in  = ge ? diff[DVSR_BITS-1:0] : rem_shift[DVSR_BITS-1:0];
            quo_in  = {quo_ff[CLOCK_BITS-2:0], ge};
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Store the candidate; rerun the divider for double speed once
            if (!pass_ff) begin
               norm_in  = cand;
               dvsr_in  = DVSR_BITS'(baud_ff) << DOUBLE_SHIFT;
               rem_in   = '0;
               quo_in   = clock_ff;
               step_in  = '0;
               pass_in  = 1'b1;
               state_in = ST_DIV;
            end else begin
               dbl_in   = cand;
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            // Hold until the response register is free, then load it
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               if (!norm_ff.usable && !dbl_ff.usable) begin
                  div_in  = '0;
                  dspd_in = 1'b0;
                  err_in  = '1;
                  oor_in  = 1'b0;
                  inv_in  = 1'b1;
               end else begin
                  div_in  = sat ? '1 : chosen.value[DIVISOR_BITS-1:0];
                  dspd_in = pick_dbl;
                  err_in  = ERROR_BITS'(chosen.err);
                  oor_in  = sat;
                  inv_in  = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      pass_ff  <= pass_in;
      baud_ff  <= baud_in;
      clock_ff <= clock_in;
      dvsr_ff  <= dvsr_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      norm_ff  <= norm_in;
      dbl_ff   <= dbl_in;
      div_ff   <= div_in;
      dspd_ff  <= dspd_in;
      err_ff   <= err_in;
      oor_ff   <= oor_in;
      inv_ff   <= inv_in;
   end

   // Drive the channels
   assign req_bus.ready           = (state_ff == ST_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.divisor_value   = div_ff;
   assign rsp_bus.double_speed    = dspd_ff;
   assign rsp_bus.rate_error      = err_ff;
   assign rsp_bus.out_of_range    = oor_ff;
   assign rsp_bus.invalid_request = inv_ff;

endmodule

### sv/ubds_check.sv
// ============================================================================
// ubds_check
// Port-level checks for the baud divisor selector, bound to the top level.
// ============================================================================
module ubds_check
   import ubds_pkg::*;
   #(parameter int DIVISOR_BITS = 12)
   (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [DIVISOR_BITS-1:0] divisor_value,
   input logic                    double_speed,
   input logic [ERROR_BITS-1:0]   rate_error,
   input logic                    out_of_range,
   input logic                    invalid_request
   );

   // Reset drops any pending response
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(divisor_value)
         && $stable(double_speed) && $stable(rate_error)
         && $stable(out_of_range) && $stable(invalid_request))
      else $error("stalled response changed");

   // An accepted request keeps the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // An invalid request carries zeroed fields and maximal error
   a_invalid_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && invalid_request |-> divisor_value == '0 && !double_speed
         && !out_of_range && &rate_error)
      else $error("invalid response fields inconsistent");

   // A valid choice has an error that fits the divisor width; saturation reads all ones
   a_valid_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !invalid_request |-> rate_error[ERROR_BITS-1:DVSR_BITS] == '0
         && (!out_of_range || &divisor_value))
      else $error("valid response fields inconsistent");

endmodule

bind uart_baud_divisor_select ubds_check #(.DIVISOR_BITS(DIVISOR_BITS)) u_ubds_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .divisor_value   (rsp_bus.divisor_value),
   .double_speed    (rsp_bus.double_speed),
   .rate_error      (rsp_bus.rate_error),
   .out_of_range    (rsp_bus.out_of_range),
   .invalid_request (rsp_bus.invalid_request)
);
